// ----- src/sia_pkg.sv -----
`timescale 1ns / 1ps

package sia_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam int SLOT_W        = 8;
    localparam int LIMIT_W       = 9;
    localparam int LIMIT_RESET   = 256;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_IN_USE = 2'd1,
        ST_NO_SLOTS   = 2'd2,
        ST_RANGE      = 2'd3
    } status_t;

    typedef struct packed {
        action_t             action;
        logic [SLOT_W-1:0]   slot_index;
    } req_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_index;
        status_t             status;
    } rsp_word_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

    // rd_en: word accepted, launch memory reads; commit: apply update and take result
    typedef struct packed {
        logic rd_en;
        logic commit;
    } sia_ctrl_t;

endpackage

// ----- src/sia_state.sv -----
`timescale 1ns / 1ps

module sia_state
    import sia_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sia_ctrl_t          ctrl,
    input  req_word_t          request,
    input  logic [LIMIT_W-1:0] limit,
    output rsp_word_t          result
);

    localparam int SLOT_CAP = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int IDX_W    = $clog2(SLOT_CAP);
    localparam int CNT_W    = IDX_W + 1;

    // in-use bitmap and free queue, both synchronous memories
    logic             bitmap_mem [SLOT_CAP];
    logic [IDX_W-1:0] fifo_mem   [SLOT_CAP];

    logic             bm_rdata_reg;
    logic [IDX_W-1:0] fifo_rdata_reg;
    action_t          action_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [CNT_W-1:0] next_fresh_reg, next_fresh_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             bm_we;
    logic [IDX_W-1:0] bm_waddr;
    logic             bm_wdata;
    logic             fifo_we;
    logic             do_fresh;
    logic             do_pop;
    logic             do_push;
    logic             in_use;
    logic [SLOT_W-1:0] granted;
    status_t          status;

    always_ff @(posedge clk) begin
        if (bm_we) begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        if (fifo_we) begin
            fifo_mem[tail_reg] <= slot_reg[IDX_W-1:0];
        end
        if (ctrl.rd_en) begin
            bm_rdata_reg   <= bitmap_mem[request.slot_index[IDX_W-1:0]];
            fifo_rdata_reg <= fifo_mem[head_reg];
            action_reg     <= request.action;
            slot_reg       <= request.slot_index;
        end
    end

    // a slot at or above next_fresh was never granted, so its bitmap entry is stale
    assign in_use = (LIMIT_W'(slot_reg) < LIMIT_W'(next_fresh_reg)) && bm_rdata_reg;

    always_comb begin
        do_fresh = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        granted  = '0;
        status   = ST_OK;
        if (action_reg == ACT_ALLOC) begin
            if (LIMIT_W'(next_fresh_reg) < limit) begin
                do_fresh = 1'b1;
                granted  = SLOT_W'(next_fresh_reg[IDX_W-1:0]);
            end else if (count_reg != '0) begin
                do_pop  = 1'b1;
                granted = SLOT_W'(fifo_rdata_reg);
            end else begin
                status = ST_NO_SLOTS;
            end
        end else begin
            if (LIMIT_W'(slot_reg) >= limit) begin
                status = ST_RANGE;
            end else if (!in_use) begin
                status = ST_NOT_IN_USE;
            end else begin
                do_push = 1'b1;
            end
        end
    end

    assign result.granted_index = granted;
    assign result.status        = status;

    always_comb begin
        bm_we           = ctrl.commit && (do_fresh || do_pop || do_push);
        bm_wdata        = !do_push;
        bm_waddr        = do_push ? slot_reg[IDX_W-1:0] : granted[IDX_W-1:0];
        fifo_we         = ctrl.commit && do_push && (count_reg < CNT_W'(SLOT_CAP));
        next_fresh_next = next_fresh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        if (ctrl.commit && do_fresh) begin
            next_fresh_next = next_fresh_reg + 1'b1;
        end
        if (ctrl.commit && do_pop) begin
            head_next  = (head_reg == IDX_W'(SLOT_CAP - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (fifo_we) begin
            tail_next  = (tail_reg == IDX_W'(SLOT_CAP - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            next_fresh_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end else begin
            next_fresh_reg <= next_fresh_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
        end
    end

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOT_CAP))
        else $error("free queue count beyond capacity");

    // queued slots are distinct and were all handed out fresh before
    a_count_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= next_fresh_reg)
        else $error("free queue holds more slots than ever granted");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && do_pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue pop did not decrement count");

    a_commit_alone: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> !ctrl.rd_en)
        else $error("new word read while previous one commits");
`endif

endmodule

// ----- src/slot_index_allocator.sv -----
`timescale 1ns / 1ps

// Slot index allocator.
// request channel (request_valid/request_ready, request): one word per
//   allocate or release. result channel (result_valid/result_ready,
//   result): exactly one word per request, in request order.
// cfg channel (cfg_valid/cfg_ready, cfg_data): writes num_blocks; always
//   ready; user must write only while no request is outstanding (not enforced).
// Allocate hands out never-used slots in ascending order, then released
//   slots in FIFO order; status reports out of slots, release of a free
//   slot, or an index at or beyond the limit.
// Flow: an accepted word's memory reads are registered at the accept edge;
//   the execute step writes the update back to the in-use bitmap and free
//   queue and registers the result once the output register is free, after
//   which the block is ready again; it takes no request before that.
// Reset: pointers and counts clear, num_blocks returns to 256; no clearing
//   pass, the bitmap is qualified by the fresh pointer.
// Stall: a pending result is held in the output register; the next request
//   is still accepted and waits in the execute step until the output frees.
module slot_index_allocator
    import sia_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  req_word_t          request,
    output logic               result_valid,
    input  logic               result_ready,
    output rsp_word_t          result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int SLOT_CAP = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

    fsm_t               state_reg, state_next;
    logic [LIMIT_W-1:0] num_blocks_reg;
    logic [LIMIT_W-1:0] limit;
    logic               result_valid_reg;
    rsp_word_t          result_reg;
    rsp_word_t          exec_result;
    sia_ctrl_t          ctrl;

    assign cfg_ready = 1'b1;
    assign limit = (num_blocks_reg > LIMIT_W'(SLOT_CAP)) ? LIMIT_W'(SLOT_CAP) : num_blocks_reg;

    always_comb begin
        state_next    = state_reg;
        request_ready = 1'b0;
        ctrl.rd_en    = 1'b0;
        ctrl.commit   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                request_ready = 1'b1;
                ctrl.rd_en    = request_valid;
                if (request_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                ctrl.commit = !result_valid_reg || result_ready;
                if (ctrl.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            num_blocks_reg   <= LIMIT_W'(LIMIT_RESET);
            result_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                num_blocks_reg <= cfg_data;
            end
            if (ctrl.commit) begin
                result_valid_reg <= 1'b1;
            end else if (result_ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.commit) begin
            result_reg <= exec_result;
        end
    end

    sia_state #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .request (request),
        .limit   (limit),
        .result  (exec_result)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> result_valid && result == $past(exec_result))
        else $error("committed word not presented on result");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> !result_valid_reg || result_ready)
        else $error("pending result overwritten");
`endif

endmodule

// ----- verif/tb_slot_index_allocator.sv -----
`timescale 1ns / 1ps

module tb_slot_index_allocator;
    import sia_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    logic               clk;
    logic               rst_n;
    logic               request_valid;
    logic               request_ready;
    req_word_t          request;
    logic               result_valid;
    logic               result_ready;
    rsp_word_t          result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    slot_index_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // allocator state as the testbench sees it
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] fresh_ptr;
    logic [SLOT_W-1:0]  free_slots [$];
    bit                 slot_busy [256];

    rsp_word_t pending_grants [$];

    bit quiet;
    bit hold_req;
    int bad_words;
    int idle_cycles;
    int n_req;
    int n_cfg;
    int st_seen [4];

    typedef struct {
        bit                 wr_cfg;
        logic [LIMIT_W-1:0] cfg_val;
        action_t            act;
        logic [SLOT_W-1:0]  idx;
        bit                 typed;
        logic [SLOT_W-1:0]  want_idx;
        status_t            want_st;
    } dir_row_t;

    typedef struct {
        logic [LIMIT_W-1:0] lim;
        int                 items;
        int                 alloc_pct;
    } phase_t;

    dir_row_t dir_tab [25];
    phase_t   plan [7];

    function automatic int slot_cap();
        return (limit_reg > 256) ? 256 : int'(limit_reg);
    endfunction

    function automatic rsp_word_t grant_outcome(input req_word_t w);
        rsp_word_t r;
        int        cap;
        cap = slot_cap();
        r.granted_index = '0;
        r.status = ST_OK;
        if (w.action == ACT_ALLOC)
        begin
            if (int'(fresh_ptr) < cap)
            begin
                r.granted_index = fresh_ptr[SLOT_W-1:0];
                slot_busy[fresh_ptr[SLOT_W-1:0]] = 1'b1;
                fresh_ptr = fresh_ptr + 1'b1;
            end
            else if (free_slots.size() != 0)
            begin
                r.granted_index = free_slots.pop_front();
                slot_busy[r.granted_index] = 1'b1;
            end
            else
                r.status = ST_NO_SLOTS;
        end
        else
        begin
            if (int'(w.slot_index) >= cap)
                r.status = ST_RANGE;
            else if (!slot_busy[w.slot_index])
                r.status = ST_NOT_IN_USE;
            else
            begin
                slot_busy[w.slot_index] = 1'b0;
                if (free_slots.size() < 256)
                    free_slots.push_back(w.slot_index);
            end
        end
        return r;
    endfunction

    // mostly allocates and releases of busy slots; the rest are stray releases
    function automatic req_word_t pick_request(input int alloc_pct);
        req_word_t w;
        int        r;
        int        start;
        w.slot_index = SLOT_W'($urandom_range(255));
        r = $urandom_range(99);
        if (r < alloc_pct)
            w.action = ACT_ALLOC;
        else
        begin
            w.action = ACT_RELEASE;
            if (r < alloc_pct + (100 - alloc_pct) * 4 / 5)
            begin
                start = $urandom_range(255);
                for (int k = 0; k < 256; k++)
                begin
                    if (slot_busy[(start + k) % 256])
                    begin
                        w.slot_index = SLOT_W'((start + k) % 256);
                        break;
                    end
                end
            end
        end
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic push_request(input req_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t guess;
        while (!quiet && $urandom_range(99) < 27)
        begin
            request_valid <= 1'b0;
            @(negedge clk);
        end
        request_valid <= 1'b1;
        request <= w;
        do @(posedge clk); while (!request_ready);
        guess = grant_outcome(w);
        pending_grants.push_back(typed ? want : guess);
        n_req++;
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        request_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        limit_reg = v;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : result_check
        rsp_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            st_seen[result.status]++;
            if (pending_grants.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("%0t: unexpected result word: granted_index %0d status %s",
                             $time, result.granted_index, result.status.name());
            end
            else
            begin
                want = pending_grants.pop_front();
                if (result.granted_index !== want.granted_index || result.status !== want.status)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("%0t: mismatch: granted_index exp %0d got %0d, status exp %s got %s",
                                 $time, want.granted_index, result.granted_index,
                                 want.status.name(), result.status.name());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request_valid && request_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_grants.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, a quiet stretch, and two long holds on request
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin
        req_word_t w;
        rsp_word_t t;

        rst_n = 1'b0;
        request_valid = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        limit_reg = LIMIT_W'(LIMIT_RESET);
        fresh_ptr = '0;
        foreach (slot_busy[i])
            slot_busy[i] = 1'b0;

        dir_tab = '{
            '{0, 0,   ACT_ALLOC,   0,   1, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   1, 1, ST_OK},
            '{0, 0,   ACT_RELEASE, 5,   1, 0, ST_NOT_IN_USE},
            '{0, 0,   ACT_RELEASE, 0,   1, 0, ST_OK},
            '{0, 0,   ACT_RELEASE, 0,   1, 0, ST_NOT_IN_USE},
            '{0, 0,   ACT_RELEASE, 255, 1, 0, ST_NOT_IN_USE},
            '{0, 0,   ACT_RELEASE, 1,   1, 0, ST_OK},
            '{1, 2,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   1, 0, ST_NO_SLOTS},
            '{0, 0,   ACT_RELEASE, 2,   1, 0, ST_RANGE},
            '{0, 0,   ACT_RELEASE, 255, 1, 0, ST_RANGE},
            '{1, 0,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   1, 0, ST_NO_SLOTS},
            '{0, 0,   ACT_RELEASE, 0,   1, 0, ST_RANGE},
            '{1, 511, ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_RELEASE, 1,   0, 0, ST_OK},
            '{1, 1,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   0, 0, ST_OK},
            '{0, 0,   ACT_RELEASE, 1,   1, 0, ST_RANGE},
            '{0, 0,   ACT_RELEASE, 0,   0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   255, 0, 0, ST_OK},
            '{0, 0,   ACT_ALLOC,   0,   1, 0, ST_NO_SLOTS}
        };

        // first phase runs the fresh pointer dry and then the free queue
        plan = '{
            '{256, 350, 90},
            '{8,   120, 40},
            '{300, 150, 50},
            '{0,   30,  50},
            '{1,   60,  50},
            '{511, 140, 45},
            '{256, 50,  60}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].wr_cfg)
                write_limit(dir_tab[i].cfg_val);
            else
            begin
                w.action = dir_tab[i].act;
                w.slot_index = dir_tab[i].idx;
                t.granted_index = dir_tab[i].want_idx;
                t.status = dir_tab[i].want_st;
                push_request(w, dir_tab[i].typed, t);
            end
        end

        foreach (plan[p])
        begin
            write_limit(plan[p].lim);
            for (int n = 0; n < plan[p].items; n++)
            begin
                quiet = (p == 0) && (n >= 200) && (n < 320);
                if ((p == 0 && n == 100) || (p == 5 && n == 50))
                    hold_req = 1'b1;
                w = pick_request(plan[p].alloc_pct);
                t = '0;
                push_request(w, 1'b0, t);
            end
        end
        quiet = 1'b0;

        request_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run: %0d requests under %0d limit settings (zero, one, small, full, saturated).",
                 n_req, n_cfg);
        $display("Results: %0d ok, %0d not in use, %0d out of slots, %0d out of range.",
                 st_seen[ST_OK], st_seen[ST_NOT_IN_USE], st_seen[ST_NO_SLOTS],
                 st_seen[ST_RANGE]);
        if (bad_words == 0 && pending_grants.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
